// ===== rtl/core/tbb_pkg.sv =====
// Shared types for the trimmed bounding box block.
// No dependencies; every other file in rtl/core but tbb_ifs refers to it by scoped names.
package tbb_pkg;

  // Sort direction of one list of extreme values
  typedef enum logic {
    ORDER_ASCEND,   // keeps the smallest values, smallest first
    ORDER_DESCEND   // keeps the largest values, largest first
  } tbb_order_t;

  // Tag that travels with the captured sums into the result pipeline
  typedef struct packed {
    logic valid;    // a model has finished, sums are on the bus
    logic too_few;  // fewer vertices than the trim count were given
  } tbb_tag_t;

endpackage

// ===== rtl/core/tbb_ifs.sv =====
// Valid/ready channel interfaces of the trimmed bounding box block.
// tbb_vertex_if carries one vertex, tbb_box_if carries one box result.
// Depends on nothing.
interface tbb_vertex_if #(
  parameter int COORD_WIDTH = 16
);
  logic                          valid;
  logic                          ready;
  logic signed [COORD_WIDTH-1:0] coord_x;
  logic signed [COORD_WIDTH-1:0] coord_y;
  logic signed [COORD_WIDTH-1:0] coord_z;
  logic                          last_vertex;

  modport source (output valid, coord_x, coord_y, coord_z, last_vertex, input ready);
  modport sink   (input valid, coord_x, coord_y, coord_z, last_vertex, output ready);
endinterface

interface tbb_box_if #(
  parameter int COORD_WIDTH = 16
);
  logic                          valid;
  logic                          ready;
  logic signed [COORD_WIDTH-1:0] center_x;
  logic signed [COORD_WIDTH-1:0] center_y;
  logic signed [COORD_WIDTH-1:0] center_z;
  logic        [COORD_WIDTH-2:0] half_x;
  logic        [COORD_WIDTH-2:0] half_y;
  logic        [COORD_WIDTH-2:0] half_z;
  logic                          too_few;

  modport source (output valid, center_x, center_y, center_z, half_x, half_y, half_z,
                  too_few, input ready);
  modport sink   (input valid, center_x, center_y, center_z, half_x, half_y, half_z,
                  too_few, output ready);
endinterface

// ===== rtl/core/trimmed_bounding_box.sv =====
// Trimmed bounding box: one vertex per cycle, six sorted extreme lists.
// Throughput: 1 vertex per cycle, set by the combinational compare-and-shift
// insertion; only a last vertex waits, if the 3-stage result pipeline is full.
// Reset: synchronous active-low rst_n empties all stages and refills the lists.
// Depends on tbb_pkg, tbb_ifs, tbb_sorted_list, tbb_box_calc.
module trimmed_bounding_box #(
  parameter int TRIM_COUNT  = 10,
  parameter int COORD_WIDTH = 16
) (
  input logic           clk,
  input logic           rst_n,
  tbb_vertex_if.sink    in_vtx,
  tbb_box_if.source     out_box
);

  localparam int SumWidth = COORD_WIDTH + $clog2(TRIM_COUNT);
  localparam int CntWidth = $clog2(TRIM_COUNT + 1);
  localparam logic [CntWidth-1:0] CntFull = CntWidth'(TRIM_COUNT);

  // Input register
  logic                          s0_v_r, s0_last_r;
  logic signed [COORD_WIDTH-1:0] s0_coord_r [3];
  logic                          s0_go, calc_ready;

  // Vertex count
  logic [CntWidth-1:0] cnt_r, cnt_inc;

  tbb_pkg::tbb_tag_t           tag;
  logic signed [SumWidth-1:0]  lo_sum [3];
  logic signed [SumWidth-1:0]  hi_sum [3];

  // A last vertex needs room in the result pipeline; others always go
  assign s0_go        = s0_v_r && (!s0_last_r || calc_ready);
  assign in_vtx.ready = !s0_v_r || s0_go;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s0_v_r <= 1'b0;
    end else if (in_vtx.ready) begin
      s0_v_r <= in_vtx.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_vtx.ready && in_vtx.valid) begin
      s0_coord_r[0] <= in_vtx.coord_x;
      s0_coord_r[1] <= in_vtx.coord_y;
      s0_coord_r[2] <= in_vtx.coord_z;
      s0_last_r     <= in_vtx.last_vertex;
    end
  end

  // Saturating count, cleared at end of model
  assign cnt_inc = (cnt_r < CntFull) ? cnt_r + CntWidth'(1) : cnt_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else if (s0_go) begin
      cnt_r <= s0_last_r ? '0 : cnt_inc;
    end
  end

  assign tag.valid   = s0_go && s0_last_r;
  assign tag.too_few = (cnt_inc < CntFull);

  // Smallest and largest lists per axis
  for (genvar a = 0; a < 3; a++) begin : g_axis
    tbb_sorted_list #(
      .TRIM_COUNT (TRIM_COUNT),
      .COORD_WIDTH(COORD_WIDTH),
      .SUM_WIDTH  (SumWidth),
      .ORDER      (tbb_pkg::ORDER_ASCEND)
    ) u_lowest (
      .clk      (clk),
      .rst_n    (rst_n),
      .en_i     (s0_go),
      .clr_i    (s0_last_r),
      .val_i    (s0_coord_r[a]),
      .sum_nxt_o(lo_sum[a])
    );

    tbb_sorted_list #(
      .TRIM_COUNT (TRIM_COUNT),
      .COORD_WIDTH(COORD_WIDTH),
      .SUM_WIDTH  (SumWidth),
      .ORDER      (tbb_pkg::ORDER_DESCEND)
    ) u_highest (
      .clk      (clk),
      .rst_n    (rst_n),
      .en_i     (s0_go),
      .clr_i    (s0_last_r),
      .val_i    (s0_coord_r[a]),
      .sum_nxt_o(hi_sum[a])
    );
  end

  tbb_box_calc #(
    .TRIM_COUNT (TRIM_COUNT),
    .COORD_WIDTH(COORD_WIDTH),
    .SUM_WIDTH  (SumWidth)
  ) u_box_calc (
    .clk     (clk),
    .rst_n   (rst_n),
    .tag_i   (tag),
    .lo_sum_i(lo_sum),
    .hi_sum_i(hi_sum),
    .ready_o (calc_ready),
    .out_box (out_box)
  );

  a_cnt_bound : assert property (@(posedge clk) disable iff (!rst_n) cnt_r <= CntFull)
    else $error("vertex count beyond trim count");

  a_cnt_clear : assert property (@(posedge clk) disable iff (!rst_n)
    s0_go && s0_last_r |=> cnt_r == '0)
    else $error("vertex count not cleared after end of model");

endmodule

// ===== rtl/core/tbb_sorted_list.sv =====
// One sorted list of the TRIM_COUNT most extreme values on one axis, with a
// running sum of its entries. Parallel compare-and-shift insertion.
// Depends on tbb_pkg.
module tbb_sorted_list #(
  parameter int                  TRIM_COUNT  = 10,
  parameter int                  COORD_WIDTH = 16,
  parameter int                  SUM_WIDTH   = 20,
  parameter tbb_pkg::tbb_order_t ORDER       = tbb_pkg::ORDER_ASCEND
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          en_i,      // take val_i this cycle
  input  logic                          clr_i,     // with en_i: refill after insertion
  input  logic signed [COORD_WIDTH-1:0] val_i,
  output logic signed [SUM_WIDTH-1:0]   sum_nxt_o  // sum of the list with val_i inserted
);

  localparam longint MaxV  = (longint'(1) <<< (COORD_WIDTH - 1)) - 1;
  localparam longint MinV  = -(longint'(1) <<< (COORD_WIDTH - 1));
  localparam longint FillV = (ORDER == tbb_pkg::ORDER_ASCEND) ? MaxV : MinV;
  localparam logic signed [COORD_WIDTH-1:0] Fill    = COORD_WIDTH'(FillV);
  localparam logic signed [SUM_WIDTH-1:0]   SumFill = SUM_WIDTH'(FillV * TRIM_COUNT);

  logic signed [COORD_WIDTH-1:0] entry_r   [TRIM_COUNT];
  logic signed [COORD_WIDTH-1:0] entry_nxt [TRIM_COUNT];
  logic        [TRIM_COUNT-1:0]  beats;
  logic signed [SUM_WIDTH-1:0]   sum_r;
  logic signed [SUM_WIDTH-1:0]   sum_nxt;

  // New value beats an entry when strictly more extreme; equal values go after
  always_comb begin
    for (int i = 0; i < TRIM_COUNT; i++) begin
      if (ORDER == tbb_pkg::ORDER_ASCEND) begin
        beats[i] = (val_i < entry_r[i]);
      end else begin
        beats[i] = (val_i > entry_r[i]);
      end
    end
  end

  // Each entry keeps its value, takes the new one, or takes its neighbour
  for (genvar i = 0; i < TRIM_COUNT; i++) begin : g_entry
    if (i == 0) begin : g_head
      assign entry_nxt[i] = beats[i] ? val_i : entry_r[i];
    end else begin : g_body
      assign entry_nxt[i] = !beats[i]     ? entry_r[i]   :
                            !beats[i - 1] ? val_i        : entry_r[i - 1];
    end
  end

  // Running sum: if the new value enters the list, it goes in and the tail entry out
  assign sum_nxt   = beats[TRIM_COUNT-1]
                   ? sum_r + SUM_WIDTH'(val_i) - SUM_WIDTH'(entry_r[TRIM_COUNT-1])
                   : sum_r;
  assign sum_nxt_o = sum_nxt;

  // List and sum registers
  always_ff @(posedge clk) begin
    if (!rst_n || (en_i && clr_i)) begin
      for (int i = 0; i < TRIM_COUNT; i++) begin
        entry_r[i] <= Fill;
      end
      sum_r <= SumFill;
    end else if (en_i) begin
      entry_r <= entry_nxt;
      sum_r   <= sum_nxt;
    end
  end

  // Order check over the stored entries
  logic ordered;
  always_comb begin
    ordered = 1'b1;
    for (int i = 0; i + 1 < TRIM_COUNT; i++) begin
      if (ORDER == tbb_pkg::ORDER_ASCEND) begin
        if (entry_r[i] > entry_r[i + 1]) ordered = 1'b0;
      end else begin
        if (entry_r[i] < entry_r[i + 1]) ordered = 1'b0;
      end
    end
  end

  a_list_ordered : assert property (@(posedge clk) disable iff (!rst_n) ordered)
    else $error("extreme value list out of order");

  a_clear_refills : assert property (@(posedge clk) disable iff (!rst_n)
    en_i && clr_i |=> sum_r == SumFill)
    else $error("list sum not refilled after end of model");

endmodule

// ===== rtl/core/tbb_box_calc.sv =====
// Result pipeline: captured sums -> trimmed means -> centre and half size.
// Three registered stages with a ready chain. Depends on tbb_pkg, tbb_box_if.
module tbb_box_calc #(
  parameter int TRIM_COUNT  = 10,
  parameter int COORD_WIDTH = 16,
  parameter int SUM_WIDTH   = 20
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  tbb_pkg::tbb_tag_t           tag_i,
  input  logic signed [SUM_WIDTH-1:0] lo_sum_i [3],
  input  logic signed [SUM_WIDTH-1:0] hi_sum_i [3],
  output logic                        ready_o,
  tbb_box_if.source                   out_box
);

  // Floor division by TRIM_COUNT as multiply by reciprocal on an offset sum
  localparam int     Lg      = $clog2(TRIM_COUNT);
  localparam int     Shift   = SUM_WIDTH + Lg;
  localparam int     RecipW  = SUM_WIDTH + 1;
  localparam int     ProdW   = SUM_WIDTH + RecipW;
  localparam logic [RecipW-1:0]    Recip  =
    RecipW'(((longint'(1) <<< Shift) + TRIM_COUNT - 1) / TRIM_COUNT);
  localparam logic [SUM_WIDTH-1:0] Offset =
    SUM_WIDTH'(longint'(TRIM_COUNT) <<< (COORD_WIDTH - 1));

  // Stage 1: captured sums
  logic                        r1_v_r, r1_few_r;
  logic signed [SUM_WIDTH-1:0] r1_lo_r [3];
  logic signed [SUM_WIDTH-1:0] r1_hi_r [3];
  // Stage 2: trimmed minimum and maximum
  logic                          r2_v_r, r2_few_r;
  logic signed [COORD_WIDTH-1:0] r2_min_r [3];
  logic signed [COORD_WIDTH-1:0] r2_max_r [3];
  logic signed [COORD_WIDTH-1:0] min_nxt [3];
  logic signed [COORD_WIDTH-1:0] max_nxt [3];
  // Output stage
  logic                          out_v_r, out_few_r;
  logic signed [COORD_WIDTH-1:0] centre_r [3];
  logic        [COORD_WIDTH-2:0] half_r   [3];
  logic signed [COORD_WIDTH-1:0] centre_nxt [3];
  logic        [COORD_WIDTH-2:0] half_nxt   [3];

  logic out_free, r2_ready, r1_ready;

  assign out_free = !out_v_r || out_box.ready;
  assign r2_ready = !r2_v_r || out_free;
  assign r1_ready = !r1_v_r || r2_ready;
  assign ready_o  = r1_ready;

  // Per-axis arithmetic
  for (genvar a = 0; a < 3; a++) begin : g_axis
    logic [SUM_WIDTH-1:0]   lo_off, hi_off;
    logic [ProdW-1:0]       lo_prod, hi_prod;
    logic [COORD_WIDTH-1:0] lo_q, hi_q;
    logic signed [COORD_WIDTH:0] sum_mm, dif_mm;

    // Offset sums are non-negative and wrap within the sum width
    assign lo_off  = SUM_WIDTH'(r1_lo_r[a]) + Offset;
    assign hi_off  = SUM_WIDTH'(r1_hi_r[a]) + Offset;
    // Quotient minus the offset is an MSB flip
    assign lo_prod = ProdW'(lo_off) * ProdW'(Recip);
    assign hi_prod = ProdW'(hi_off) * ProdW'(Recip);
    assign lo_q    = lo_prod[Shift +: COORD_WIDTH];
    assign hi_q    = hi_prod[Shift +: COORD_WIDTH];
    assign min_nxt[a] = {~lo_q[COORD_WIDTH-1], lo_q[COORD_WIDTH-2:0]};
    assign max_nxt[a] = {~hi_q[COORD_WIDTH-1], hi_q[COORD_WIDTH-2:0]};

    // Halvings round toward minus infinity: arithmetic shift of the wide sum
    assign sum_mm = (COORD_WIDTH+1)'(r2_min_r[a]) + (COORD_WIDTH+1)'(r2_max_r[a]);
    assign dif_mm = (COORD_WIDTH+1)'(r2_max_r[a]) - (COORD_WIDTH+1)'(r2_min_r[a]);
    assign centre_nxt[a] = r2_few_r ? '0 : sum_mm[COORD_WIDTH:1];
    assign half_nxt[a]   = r2_few_r ? '0 : dif_mm[COORD_WIDTH-1:1];
  end

  // Valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      r1_v_r  <= 1'b0;
      r2_v_r  <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      if (r1_ready) r1_v_r  <= tag_i.valid;
      if (r2_ready) r2_v_r  <= r1_v_r;
      if (out_free) out_v_r <= r2_v_r;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (r1_ready && tag_i.valid) begin
      r1_few_r <= tag_i.too_few;
      r1_lo_r  <= lo_sum_i;
      r1_hi_r  <= hi_sum_i;
    end
    if (r2_ready && r1_v_r) begin
      r2_few_r <= r1_few_r;
      r2_min_r <= min_nxt;
      r2_max_r <= max_nxt;
    end
    if (out_free && r2_v_r) begin
      out_few_r <= r2_few_r;
      centre_r  <= centre_nxt;
      half_r    <= half_nxt;
    end
  end

  assign out_box.valid    = out_v_r;
  assign out_box.too_few  = out_few_r;
  assign out_box.center_x = centre_r[0];
  assign out_box.center_y = centre_r[1];
  assign out_box.center_z = centre_r[2];
  assign out_box.half_x   = half_r[0];
  assign out_box.half_y   = half_r[1];
  assign out_box.half_z   = half_r[2];

  a_few_zero : assert property (@(posedge clk) disable iff (!rst_n)
    out_v_r && out_few_r |-> centre_r[0] == '0 && centre_r[1] == '0 && centre_r[2] == '0 &&
                             half_r[0] == '0 && half_r[1] == '0 && half_r[2] == '0)
    else $error("box fields not zero on a too-few result");

endmodule

// ===== tb/trimmed_bounding_box_tb.sv =====
// Testbench for trimmed_bounding_box: streams vertex models into the block and checks each box.
// Holds its own model of the sorted extreme lists; needs tbb_pkg, tbb_ifs and the block's RTL.
module trimmed_bounding_box_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int TRIM = 10;
  localparam int CW   = 16;
  localparam int RANDOM_ITEMS = 1600;

  typedef logic signed [CW-1:0] coord_t;

  localparam coord_t MAXV = 16'sh7FFF;
  localparam coord_t MINV = 16'sh8000;

  // Value styles for random models
  localparam int STYLE_SPREAD   = 0;  // anywhere in the range
  localparam int STYLE_CLUSTER  = 1;  // narrow band, many equal values
  localparam int STYLE_EXTREMES = 2;  // mostly range limits and zero

  typedef struct packed {
    logic signed [CW-1:0] center_x;
    logic signed [CW-1:0] center_y;
    logic signed [CW-1:0] center_z;
    logic [CW-2:0]        half_x;
    logic [CW-2:0]        half_y;
    logic [CW-2:0]        half_z;
    logic                 too_few;
  } box_t;

  logic clk = 1'b0;
  logic rst_n;

  tbb_vertex_if #(.COORD_WIDTH(CW)) vtx ();
  tbb_box_if    #(.COORD_WIDTH(CW)) box ();

  trimmed_bounding_box #(
    .TRIM_COUNT (TRIM),
    .COORD_WIDTH(CW)
  ) DUT (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_vtx (vtx),
    .out_box(box)
  );

  always #10 clk = ~clk;

  // Model state: per axis the TRIM smallest (ascending) and largest (descending) values
  coord_t smallest [3][TRIM];
  coord_t largest  [3][TRIM];
  int     vertices_seen;

  box_t   pending_boxes[$];
  int     errors;
  int     vertices_sent;
  coord_t cluster_base;

  // Shared between the sender and the receiver
  bit     no_idle;
  int     hold_req;

  function automatic void clear_lists();
    for (int a = 0; a < 3; a++) begin
      for (int i = 0; i < TRIM; i++) begin
        smallest[a][i] = MAXV;
        largest[a][i]  = MINV;
      end
    end
    vertices_seen = 0;
  endfunction

  function automatic int floor_div(int s, int d);
    int q;
    q = s / d;
    if ((s % d) != 0 && s < 0) q--;
    return q;
  endfunction

  // Sorted insertion; an equal value goes after the entries equal to it
  function automatic void insert_extreme(int axis, coord_t v, tbb_pkg::tbb_order_t order);
    coord_t list [TRIM];
    int     pos;
    pos = TRIM;
    for (int i = 0; i < TRIM; i++)
      list[i] = (order == tbb_pkg::ORDER_ASCEND) ? smallest[axis][i] : largest[axis][i];
    for (int i = 0; i < TRIM; i++) begin
      if (pos == TRIM && ((order == tbb_pkg::ORDER_ASCEND) ? (v < list[i]) : (v > list[i])))
        pos = i;
    end
    if (pos < TRIM) begin
      for (int i = TRIM - 1; i > pos; i--) list[i] = list[i-1];
      list[pos] = v;
    end
    for (int i = 0; i < TRIM; i++) begin
      if (order == tbb_pkg::ORDER_ASCEND) smallest[axis][i] = list[i];
      else largest[axis][i] = list[i];
    end
  endfunction

  // Takes one accepted vertex in; returns 1 with the box when it closes a model
  function automatic bit fold_vertex(coord_t x, coord_t y, coord_t z, logic last,
                                     output box_t bx);
    coord_t v [3];
    int     lo_sum, hi_sum, tmin, tmax;
    int     ctr [3];
    int     hlf [3];
    v[0] = x;
    v[1] = y;
    v[2] = z;
    bx = '0;
    for (int a = 0; a < 3; a++) begin
      insert_extreme(a, v[a], tbb_pkg::ORDER_ASCEND);
      insert_extreme(a, v[a], tbb_pkg::ORDER_DESCEND);
    end
    if (vertices_seen < TRIM) vertices_seen++;
    if (!last) return 1'b0;

    if (vertices_seen < TRIM) begin
      bx.too_few = 1'b1;
    end else begin
      for (int a = 0; a < 3; a++) begin
        lo_sum = 0;
        hi_sum = 0;
        for (int i = 0; i < TRIM; i++) begin
          lo_sum += smallest[a][i];
          hi_sum += largest[a][i];
        end
        tmin   = floor_div(lo_sum, TRIM);
        tmax   = floor_div(hi_sum, TRIM);
        ctr[a] = floor_div(tmin + tmax, 2);
        hlf[a] = floor_div(tmax - tmin, 2);
      end
      bx.center_x = ctr[0][CW-1:0];
      bx.center_y = ctr[1][CW-1:0];
      bx.center_z = ctr[2][CW-1:0];
      bx.half_x   = hlf[0][CW-2:0];
      bx.half_y   = hlf[1][CW-2:0];
      bx.half_z   = hlf[2][CW-2:0];
    end
    clear_lists();
    return 1'b1;
  endfunction

  // Offer one vertex after a random gap and wait for its transaction
  task automatic send_vertex(coord_t x, coord_t y, coord_t z, logic last);
    int   gap;
    int   roll;
    box_t bx;
    roll = $urandom_range(0, 99);
    if (no_idle || roll < 60) gap = 0;
    else if (roll < 92) gap = $urandom_range(1, 3);
    else gap = $urandom_range(10, 40);
    if (gap > 0) begin
      vtx.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    vtx.valid       <= 1'b1;
    vtx.coord_x     <= x;
    vtx.coord_y     <= y;
    vtx.coord_z     <= z;
    vtx.last_vertex <= last;
    do @(posedge clk); while (vtx.ready !== 1'b1);
    vertices_sent++;
    if (fold_vertex(x, y, z, last, bx)) pending_boxes = {pending_boxes, bx};
  endtask

  function automatic coord_t rand_coord(int style);
    int roll;
    roll = $urandom_range(0, 9);
    case (style)
      STYLE_CLUSTER: return coord_t'(cluster_base + $urandom_range(0, 3));
      STYLE_EXTREMES: begin
        if (roll < 3) return MAXV;
        if (roll < 6) return MINV;
        if (roll < 7) return '0;
        if (roll < 8) return '1;
        return coord_t'($urandom);
      end
      default: return coord_t'($urandom);
    endcase
  endfunction

  task automatic send_model(int len, int style);
    cluster_base = coord_t'($urandom);
    for (int i = 0; i < len; i++)
      send_vertex(rand_coord(style), rand_coord(style), rand_coord(style), i == len - 1);
  endtask

  // Models shorter than the trim count, including the single-vertex one
  task automatic test_too_few();
    send_vertex(MINV, MAXV, '0, 1'b1);
    for (int i = 0; i < TRIM - 1; i++)
      send_vertex(coord_t'($urandom), coord_t'($urandom), coord_t'($urandom),
                  i == TRIM - 2);
  endtask

  // Exactly the trim count: all equal on x and y, alternating limits on z
  // (sum of -5 gives a negative mean that must round down)
  task automatic test_range_limits();
    for (int i = 0; i < TRIM; i++)
      send_vertex(MINV, MAXV, (i % 2) ? MAXV : MINV, i == TRIM - 1);
  endtask

  // Sink stalls for a long stretch while short models keep arriving
  task automatic test_back_pressure();
    no_idle  = 1'b1;
    hold_req = 150;
    for (int m = 0; m < 14; m++)
      send_model((m % 3 == 0) ? TRIM : 1, STYLE_SPREAD);
    no_idle = 1'b0;
  endtask

  // Mostly well-formed models of varied length and value style
  task automatic test_random_models();
    int start;
    int roll;
    int len;
    int models;
    start  = vertices_sent;
    models = 0;
    while (vertices_sent - start < RANDOM_ITEMS) begin
      no_idle = (models < 5);  // opening stretch at full rate
      roll = $urandom_range(0, 99);
      if (roll < 15) len = $urandom_range(1, TRIM - 1);
      else if (roll < 90) len = $urandom_range(TRIM, 30);
      else len = $urandom_range(31, 80);
      send_model(len, $urandom_range(STYLE_SPREAD, STYLE_EXTREMES));
      models++;
    end
    no_idle = 1'b0;
  endtask

  function automatic void check_field(string name, logic signed [31:0] want,
                                      logic signed [31:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch: expected %0d, actual %0d", $time, name, want, got);
      errors++;
    end
  endfunction

  // Result side: checks each box transaction and drives ready
  initial begin
    int   stall_left;
    int   roll;
    box_t want;
    stall_left = 0;
    box.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n === 1'b1 && box.valid === 1'b1 && box.ready === 1'b1) begin
        if (pending_boxes.size() == 0) begin
          $display("%0t: box with nothing expected: centre %0d %0d %0d, too_few %0b",
                   $time, box.center_x, box.center_y, box.center_z, box.too_few);
          errors++;
        end else begin
          want = pending_boxes.pop_front();
          check_field("center_x", $signed(want.center_x), box.center_x);
          check_field("center_y", $signed(want.center_y), box.center_y);
          check_field("center_z", $signed(want.center_z), box.center_z);
          check_field("half_x", {17'd0, want.half_x}, {17'd0, box.half_x});
          check_field("half_y", {17'd0, want.half_y}, {17'd0, box.half_y});
          check_field("half_z", {17'd0, want.half_z}, {17'd0, box.half_z});
          check_field("too_few", {31'd0, want.too_few}, {31'd0, box.too_few});
        end
      end
      if (hold_req > 0) begin
        stall_left = hold_req;
        hold_req   = 0;
      end
      if (stall_left > 0) begin
        box.ready <= 1'b0;
        stall_left--;
      end else if (no_idle) begin
        box.ready <= 1'b1;
      end else begin
        roll = $urandom_range(0, 99);
        if (roll < 70) begin
          box.ready <= 1'b1;
        end else if (roll < 95) begin
          box.ready <= 1'b0;
          stall_left = $urandom_range(0, 2);
        end else begin
          box.ready <= 1'b0;
          stall_left = $urandom_range(10, 40);
        end
      end
    end
  end

  // Test sequence
  initial begin
    errors        = 0;
    vertices_sent = 0;
    no_idle       = 1'b0;
    hold_req      = 0;
    clear_lists();
    rst_n           <= 1'b0;
    vtx.valid       <= 1'b0;
    vtx.coord_x     <= '0;
    vtx.coord_y     <= '0;
    vtx.coord_z     <= '0;
    vtx.last_vertex <= 1'b0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_too_few();
    test_range_limits();
    test_back_pressure();
    test_random_models();

    vtx.valid <= 1'b0;
    while (pending_boxes.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (errors == 0) begin
      $display("PASS trimmed_bounding_box");
    end else begin
      $display("FAIL trimmed_bounding_box");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #20_000_000;
    $display("FAIL trimmed_bounding_box");
    $finish;
  end

endmodule
